// ----- rtl/core/mcpg_pkg.sv -----
// shared types and constants of the midpoint circle point generator
`default_nettype none
package mcpg_pkg;

    // coordinate precision of centre and radius
    localparam int C_COORD_BITS   = 10;
    // step counters carry a sign bit, the decision four more bits
    localparam int C_STEP_BITS    = C_COORD_BITS + 1;
    localparam int C_DEC_BITS     = C_COORD_BITS + 4;
    // width of the emitted point coordinates
    localparam int C_PT_BITS      = 12;
    // input field widths
    localparam int C_IN_BITS      = 10;

    // points emitted per step
    localparam int C_PTS_PER_STEP = 8;
    localparam int C_IDX_BITS     = $clog2(C_PTS_PER_STEP);

    // queue between front and back
    localparam int C_Q_DEPTH      = 2;
    localparam int C_Q_PTR_BITS   = (C_Q_DEPTH > 1) ? $clog2(C_Q_DEPTH) : 1;
    localparam int C_Q_CNT_BITS   = $clog2(C_Q_DEPTH + 1);

    // decision constants
    localparam logic signed [C_DEC_BITS-1:0] C_DEC_INIT     = C_DEC_BITS'(3);
    localparam logic signed [C_DEC_BITS-1:0] C_DEC_DIAG_ADD = C_DEC_BITS'(10);
    localparam logic signed [C_DEC_BITS-1:0] C_DEC_FLAT_ADD = C_DEC_BITS'(6);

    // item modes
    typedef enum logic {
        MODE_START   = 1'b0,
        MODE_ADVANCE = 1'b1
    } t_mode;

    // input item
    typedef struct packed {
        logic                 mode;
        logic [C_IN_BITS-1:0] center_x;
        logic [C_IN_BITS-1:0] center_y;
        logic [C_IN_BITS-1:0] radius;
    } t_in_item;

    // result item
    typedef struct packed {
        logic signed [C_PT_BITS-1:0] point_x;
        logic signed [C_PT_BITS-1:0] point_y;
        logic                        last_of_step;
        logic                        circle_done;
    } t_out_item;

    // one step handed from front to back
    typedef struct packed {
        logic [C_COORD_BITS-1:0]       cx;
        logic [C_COORD_BITS-1:0]       cy;
        logic signed [C_STEP_BITS-1:0] x;
        logic signed [C_STEP_BITS-1:0] y;
        logic                          done;
    } t_job;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic valid;
    } t_q_status;

endpackage
`default_nettype wire

// ----- rtl/core/midpoint_circle_point_generator.sv -----
// top level of the midpoint circle point generator
//
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_stall   i_in_item  (mode, centre, radius)
//  output    out        o_out_valid / i_out_stall o_out_item (point, last, done)
//
// a start or active advance item yields eight points, one per cycle unless the
// output stalls, so the single output register paces the items.
// with the back part idle, the first point passes queue, job and output registers.
// the front takes one item per cycle until the two-entry step queue fills.
// reset is synchronous and active low; it clears the circle state and queue.
// output stall holds the point register and backs up through the queue.
`default_nettype none
module midpoint_circle_point_generator (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire mcpg_pkg::t_in_item   i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output mcpg_pkg::t_out_item       o_out_item
);

    logic                 w_accept;
    logic                 w_push;
    logic                 w_pop;
    mcpg_pkg::t_job       w_front_job;
    mcpg_pkg::t_job       w_q_job;
    mcpg_pkg::t_q_status  w_q_status;

    // input handshake
    assign o_in_stall = w_q_status.full;
    assign w_accept   = i_in_valid && !w_q_status.full;

    mcpg_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_in_item),
        .o_push   (w_push),
        .o_job    (w_front_job)
    );

    mcpg_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_front_job),
        .i_pop    (w_pop),
        .o_status (w_q_status),
        .o_job    (w_q_job)
    );

    mcpg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (w_q_status),
        .i_job       (w_q_job),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // a full queue always has a step waiting for the back part
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_status.full |-> w_q_status.valid)
        else $error("queue full while empty");

    // the back part only pops a queued step
    a_pop_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_status.valid)
        else $error("pop from empty queue");

    // a stalled point stays valid and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled point changed");

    // reset leaves no result and no stall
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("outputs not cleared by reset");

endmodule
`default_nettype wire

// ----- rtl/core/mcpg_front.sv -----
// front part: accepts items, keeps the circle state, runs the decision step
`default_nettype none
module mcpg_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire mcpg_pkg::t_in_item  i_item,
    output logic                     o_push,
    output mcpg_pkg::t_job           o_job
);

    logic [mcpg_pkg::C_COORD_BITS-1:0]       r_cx, n_cx;
    logic [mcpg_pkg::C_COORD_BITS-1:0]       r_cy, n_cy;
    logic signed [mcpg_pkg::C_STEP_BITS-1:0] r_x, n_x;
    logic signed [mcpg_pkg::C_STEP_BITS-1:0] r_y, n_y;
    logic signed [mcpg_pkg::C_DEC_BITS-1:0]  r_d, n_d;
    logic                                    r_active, n_active;

    logic [mcpg_pkg::C_COORD_BITS-1:0]       w_rad;
    logic signed [mcpg_pkg::C_DEC_BITS-1:0]  w_dx;
    logic signed [mcpg_pkg::C_DEC_BITS-1:0]  w_dy;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_d      <= '0;
            r_active <= 1'b0;
        end else begin
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_x      <= n_x;
            r_y      <= n_y;
            r_d      <= n_d;
            r_active <= n_active;
        end
    end

    // start setup and one octant step
    always_comb begin
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_x      = r_x;
        n_y      = r_y;
        n_d      = r_d;
        n_active = r_active;
        o_push   = 1'b0;
        o_job    = '0;
        w_rad    = mcpg_pkg::C_COORD_BITS'(i_item.radius);
        w_dx     = mcpg_pkg::C_DEC_BITS'(r_x);
        w_dy     = mcpg_pkg::C_DEC_BITS'(r_y);
        if (i_accept) begin
            if (i_item.mode == mcpg_pkg::MODE_START) begin
                n_cx     = mcpg_pkg::C_COORD_BITS'(i_item.center_x);
                n_cy     = mcpg_pkg::C_COORD_BITS'(i_item.center_y);
                n_x      = '0;
                n_y      = $signed({1'b0, w_rad});
                n_d      = mcpg_pkg::C_DEC_INIT
                         - $signed(mcpg_pkg::C_DEC_BITS'({w_rad, 1'b0}));
                n_active = 1'b1;
                o_push   = 1'b1;
                o_job    = '{cx: n_cx, cy: n_cy, x: n_x, y: n_y, done: 1'b0};
            end else if (r_active) begin
                if (r_d > 0) begin
                    n_d = r_d + ((w_dx - w_dy) <<< 2) + mcpg_pkg::C_DEC_DIAG_ADD;
                    n_y = r_y - mcpg_pkg::C_STEP_BITS'(1);
                end else begin
                    n_d = r_d + (w_dx <<< 2) + mcpg_pkg::C_DEC_FLAT_ADD;
                end
                n_x      = r_x + mcpg_pkg::C_STEP_BITS'(1);
                n_active = !(n_x > n_y);
                o_push   = 1'b1;
                o_job    = '{cx: r_cx, cy: r_cy, x: n_x, y: n_y, done: n_x > n_y};
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/mcpg_queue.sv -----
// short step queue between front and back
`default_nettype none
module mcpg_queue (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire mcpg_pkg::t_job        i_job,
    input  wire logic                  i_pop,
    output mcpg_pkg::t_q_status        o_status,
    output mcpg_pkg::t_job             o_job
);

    mcpg_pkg::t_job                    r_mem [mcpg_pkg::C_Q_DEPTH];
    logic [mcpg_pkg::C_Q_PTR_BITS-1:0] r_wr, n_wr;
    logic [mcpg_pkg::C_Q_PTR_BITS-1:0] r_rd, n_rd;
    logic [mcpg_pkg::C_Q_CNT_BITS-1:0] r_cnt, n_cnt;

    // pointer and fill count
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == mcpg_pkg::C_Q_PTR_BITS'(mcpg_pkg::C_Q_DEPTH - 1))
                 ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == mcpg_pkg::C_Q_PTR_BITS'(mcpg_pkg::C_Q_DEPTH - 1))
                 ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_status.full  = (r_cnt == mcpg_pkg::C_Q_CNT_BITS'(mcpg_pkg::C_Q_DEPTH));
    assign o_status.valid = (r_cnt != '0);
    assign o_job          = r_mem[r_rd];

endmodule
`default_nettype wire

// ----- rtl/core/mcpg_back.sv -----
// back part: walks the eight mirrored points of a step into the output register
`default_nettype none
module mcpg_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire mcpg_pkg::t_q_status  i_q_status,
    input  wire mcpg_pkg::t_job       i_job,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output mcpg_pkg::t_out_item       o_out_item
);

    mcpg_pkg::t_job                  r_job;
    logic                            r_busy;
    logic [mcpg_pkg::C_IDX_BITS-1:0] r_idx;
    logic                            r_out_valid;
    mcpg_pkg::t_out_item             r_out;

    logic                            w_adv;
    logic                            w_last;
    logic signed [mcpg_pkg::C_PT_BITS-1:0] w_cx, w_cy, w_a, w_b, w_px, w_py;

    // output slot free and a point to place
    assign w_adv  = r_busy && (!r_out_valid || !i_out_stall);
    assign w_last = (r_idx == mcpg_pkg::C_IDX_BITS'(mcpg_pkg::C_PTS_PER_STEP - 1));
    assign o_pop  = i_q_status.valid && (!r_busy || (w_adv && w_last));

    // mirror select: bit 2 swaps axes, bit 1 negates row, bit 0 negates column
    always_comb begin
        w_cx = $signed(mcpg_pkg::C_PT_BITS'(r_job.cx));
        w_cy = $signed(mcpg_pkg::C_PT_BITS'(r_job.cy));
        if (r_idx[2]) begin
            w_a = mcpg_pkg::C_PT_BITS'(r_job.y);
            w_b = mcpg_pkg::C_PT_BITS'(r_job.x);
        end else begin
            w_a = mcpg_pkg::C_PT_BITS'(r_job.x);
            w_b = mcpg_pkg::C_PT_BITS'(r_job.y);
        end
        w_px = r_idx[0] ? (w_cx - w_a) : (w_cx + w_a);
        w_py = r_idx[1] ? (w_cy - w_b) : (w_cy + w_b);
    end

    // job and point index control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (w_adv) begin
                r_busy <= !w_last;
                r_idx  <= r_idx + 1'b1;
            end
            if (!r_out_valid || !i_out_stall) begin
                r_out_valid <= r_busy;
            end
        end
    end

    // job and output payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (w_adv) begin
            r_out.point_x      <= w_px;
            r_out.point_y      <= w_py;
            r_out.last_of_step <= w_last;
            r_out.circle_done  <= r_job.done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
`default_nettype wire
